// File: src/icmp_message_check_core_defines.svh
`ifndef ICMP_MESSAGE_CHECK_CORE_DEFINES_SVH
`define ICMP_MESSAGE_CHECK_CORE_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define ICMC_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("icmc check failed");

// implication checked from the same edge
`define ICMC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("icmc check failed");

// implication checked on the following edge
`define ICMC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("icmc check failed");

`endif

// File: src/icmc_pkg.sv
`timescale 1ns / 1ps

package icmc_pkg;

   localparam logic [15:0] MAX_MESSAGE_BYTES = 16'hFFFF;
   localparam logic [15:0] HEADER_BYTES      = 16'd8;

   // header type values
   localparam logic [7:0] TYPE_ECHO_REPLY   = 8'd0;
   localparam logic [7:0] TYPE_UNREACHABLE  = 8'd3;
   localparam logic [7:0] TYPE_ECHO_REQUEST = 8'd8;

   // header byte positions
   localparam logic [2:0] POS_TYPE      = 3'd0;
   localparam logic [2:0] POS_CODE      = 3'd1;
   localparam logic [2:0] POS_CSUM_HI   = 3'd2;
   localparam logic [2:0] POS_CSUM_LO   = 3'd3;
   localparam logic [2:0] POS_FIRST_HI  = 3'd4;
   localparam logic [2:0] POS_FIRST_LO  = 3'd5;
   localparam logic [2:0] POS_SECOND_HI = 3'd6;
   localparam logic [2:0] POS_SECOND_LO = 3'd7;

   localparam logic [1:0] KIND_ECHO_REPLY   = 2'd0;
   localparam logic [1:0] KIND_UNREACHABLE  = 2'd1;
   localparam logic [1:0] KIND_ECHO_REQUEST = 2'd2;
   localparam logic [1:0] KIND_OTHER        = 2'd3;

   localparam logic [2:0] VERDICT_OK        = 3'd0;
   localparam logic [2:0] VERDICT_SHORT     = 3'd1;
   localparam logic [2:0] VERDICT_BAD_TYPE  = 3'd2;
   localparam logic [2:0] VERDICT_BAD_CODE  = 3'd3;
   localparam logic [2:0] VERDICT_BAD_SUM   = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } icmc_req_type;

   typedef struct packed {
      logic [1:0]  message_kind;
      logic [7:0]  message_code;
      logic [15:0] first_word;
      logic [15:0] second_word;
      logic [15:0] message_length;
      logic [2:0]  verdict;
   } icmc_rsp_type;

endpackage

// File: src/icmp_message_check_core.sv
`timescale 1ns / 1ps

// channel | ports                        | beat
// --------+------------------------------+------------------------------------
// request | req_valid req_ready req_data | one message byte, last_byte marks end
// result  | rsp_valid rsp_ready rsp_data | one verdict per message
//
// one byte a cycle: a byte pair or odd tail byte takes one add-and-fold into the
// running sum; each beat feeds header capture; the last one loads the output.
// a two-deep output (result register plus skid) lets bytes keep flowing while a
// result waits; req_ready drops only when both output slots hold results.
// reset is synchronous and clears all message state and both output slots.

module icmp_message_check_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  icmc_pkg::icmc_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output icmc_pkg::icmc_rsp_type rsp_data
);
   import icmc_pkg::*;

   logic [15:0] count_ff, count_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  pending_ff, pending_in;
   logic        half_ff, half_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  code_ff, code_in;
   logic [15:0] csum_ff, csum_in;
   logic [15:0] first_ff, first_in;
   logic [15:0] second_ff, second_in;

   logic         out_valid_ff, out_valid_in;
   icmc_rsp_type out_ff, out_in;
   logic         skid_valid_ff, skid_valid_in;
   icmc_rsp_type skid_ff, skid_in;

   logic         accept;
   logic         push;
   logic         pop;
   logic         in_header;
   logic [2:0]   pos;
   logic [7:0]   sum_byte;
   logic         do_add;
   logic [15:0]  add_word;
   logic [16:0]  raw_sum;
   logic [15:0]  folded;
   logic [15:0]  next_count;
   logic [15:0]  next_sum;
   logic [7:0]   next_type;
   logic [7:0]   next_code;
   logic [15:0]  next_csum;
   logic [15:0]  next_first;
   logic [15:0]  next_second;
   logic [1:0]   kind;
   logic [2:0]   verdict;
   icmc_rsp_type result;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign push      = accept && req_data.last_byte;
   assign pop       = out_valid_ff && rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign in_header = (count_ff < HEADER_BYTES);
   assign pos       = count_ff[2:0];
   // checksum field counts as zero in the sum
   assign sum_byte  = (in_header && (pos == POS_CSUM_HI || pos == POS_CSUM_LO)) ?
                      8'h00 : req_data.data_byte;

   always_comb begin
      do_add   = 1'b0;
      add_word = 16'h0000;
      if (half_ff) begin
         do_add   = 1'b1;
         add_word = {pending_ff, sum_byte};
      end else if (req_data.last_byte) begin
         // odd tail byte padded with a zero low byte
         do_add   = 1'b1;
         add_word = {sum_byte, 8'h00};
      end
   end

   assign raw_sum = {1'b0, sum_ff} + {1'b0, add_word};
   assign folded  = raw_sum[15:0] + {15'd0, raw_sum[16]};
   assign next_sum = do_add ? folded : sum_ff;

   assign next_count = (count_ff == MAX_MESSAGE_BYTES) ? count_ff : count_ff + 16'd1;

   always_comb begin
      next_type   = type_ff;
      next_code   = code_ff;
      next_csum   = csum_ff;
      next_first  = first_ff;
      next_second = second_ff;
      if (in_header) begin
         case (pos)
            POS_TYPE:      next_type          = req_data.data_byte;
            POS_CODE:      next_code          = req_data.data_byte;
            POS_CSUM_HI:   next_csum[15:8]    = req_data.data_byte;
            POS_CSUM_LO:   next_csum[7:0]     = req_data.data_byte;
            POS_FIRST_HI:  next_first[15:8]   = req_data.data_byte;
            POS_FIRST_LO:  next_first[7:0]    = req_data.data_byte;
            POS_SECOND_HI: next_second[15:8]  = req_data.data_byte;
            POS_SECOND_LO: next_second[7:0]   = req_data.data_byte;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (next_type)
         TYPE_ECHO_REPLY:   kind = KIND_ECHO_REPLY;
         TYPE_UNREACHABLE:  kind = KIND_UNREACHABLE;
         TYPE_ECHO_REQUEST: kind = KIND_ECHO_REQUEST;
         default:           kind = KIND_OTHER;
      endcase

      if (next_count < HEADER_BYTES) begin
         verdict = VERDICT_SHORT;
      end else if (kind == KIND_OTHER) begin
         verdict = VERDICT_BAD_TYPE;
      end else if (kind != KIND_UNREACHABLE && next_code != 8'h00) begin
         verdict = VERDICT_BAD_CODE;
      end else if (~next_sum != next_csum) begin
         verdict = VERDICT_BAD_SUM;
      end else begin
         verdict = VERDICT_OK;
      end

      result.message_kind   = kind;
      result.message_code   = next_code;
      result.first_word     = next_first;
      result.second_word    = next_second;
      result.message_length = next_count;
      result.verdict        = verdict;
   end

   always_comb begin
      count_in   = count_ff;
      sum_in     = sum_ff;
      pending_in = pending_ff;
      half_in    = half_ff;
      type_in    = type_ff;
      code_in    = code_ff;
      csum_in    = csum_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      if (push) begin
         // message done, start the next one from zero
         count_in   = 16'd0;
         sum_in     = 16'd0;
         pending_in = 8'd0;
         half_in    = 1'b0;
         type_in    = 8'd0;
         code_in    = 8'd0;
         csum_in    = 16'd0;
         first_in   = 16'd0;
         second_in  = 16'd0;
      end else if (accept) begin
         count_in   = next_count;
         sum_in     = next_sum;
         pending_in = half_ff ? pending_ff : sum_byte;
         half_in    = !half_ff;
         type_in    = next_type;
         code_in    = next_code;
         csum_in    = next_csum;
         first_in   = next_first;
         second_in  = next_second;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_in       = result;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= 16'd0;
         sum_ff        <= 16'd0;
         pending_ff    <= 8'd0;
         half_ff       <= 1'b0;
         type_ff       <= 8'd0;
         code_ff       <= 8'd0;
         csum_ff       <= 16'd0;
         first_ff      <= 16'd0;
         second_ff     <= 16'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         pending_ff    <= pending_in;
         half_ff       <= half_in;
         type_ff       <= type_in;
         code_ff       <= code_in;
         csum_ff       <= csum_in;
         first_ff      <= first_in;
         second_ff     <= second_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

// File: src/icmc_checker.sv
`timescale 1ns / 1ps
`include "icmp_message_check_core_defines.svh"

module icmc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input icmc_pkg::icmc_req_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input icmc_pkg::icmc_rsp_type rsp_data
);
   import icmc_pkg::*;

   logic req_seen;
   assign req_seen = req_valid && req_ready && req_data.last_byte;

   // a stalled result holds
   `ICMC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   `ICMC_ASSERT_IMPLY(a_verdict_range, clock, reset, rsp_valid, rsp_data.verdict <= VERDICT_BAD_SUM)

   // short verdict exactly when fewer than eight bytes were counted
   `ICMC_ASSERT_IMPLY(a_short_len, clock, reset, rsp_valid, (rsp_data.message_length < HEADER_BYTES) == (rsp_data.verdict == VERDICT_SHORT))

   `ICMC_ASSERT_IMPLY(a_bad_type, clock, reset, rsp_valid && rsp_data.message_length >= HEADER_BYTES && rsp_data.message_kind == KIND_OTHER, rsp_data.verdict == VERDICT_BAD_TYPE)

   // a last beat taken with no result pending shows a result next cycle
   `ICMC_ASSERT_NEXT(a_result_out, clock, reset, req_seen && !rsp_valid, rsp_valid)

endmodule

bind icmp_message_check_core icmc_checker u_icmc_checker (.*);
